### rtl/stable_priority_queue_assert.svh
// Assertion macros for the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stable_priority_queue: assertion failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stable_priority_queue: assertion failed");

`else

`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/spq_pkg.sv
package spq_pkg;

   localparam int CAPACITY_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 8;

   localparam int NAME_W       = 24;
   localparam int STATUS_W     = 2;
   localparam int SERVED_PRI_W = 8;
   localparam int OCC_W        = 5;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXECUTE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic ins;   // insert new entry, shift larger ones back
      logic rem;   // drop front entry, shift all forward
   } cell_ctrl_type;

endpackage

### rtl/spq_cell.sv
module spq_cell #(
   parameter int PRI_W = spq_pkg::PRIORITY_BITS_DEF
) (
   input  logic                      clock,
   input  spq_pkg::cell_ctrl_type    ctrl,
   input  logic                      occupied,
   input  logic [spq_pkg::NAME_W-1:0] new_name,
   input  logic [PRI_W-1:0]          new_pri,
   input  logic                      left_after,
   input  logic [spq_pkg::NAME_W-1:0] left_name,
   input  logic [PRI_W-1:0]          left_pri,
   input  logic [spq_pkg::NAME_W-1:0] right_name,
   input  logic [PRI_W-1:0]          right_pri,
   output logic                      after,
   output logic [spq_pkg::NAME_W-1:0] name,
   output logic [PRI_W-1:0]          pri
);
   import spq_pkg::*;

   logic [NAME_W-1:0] name_ff, name_in;
   logic [PRI_W-1:0]  pri_ff, pri_in;

   // New entry belongs at or before this slot (stable: equal stays ahead).
   assign after = !(occupied && (pri_ff <= new_pri));

   always_comb begin
      name_in = name_ff;
      pri_in  = pri_ff;
      if (ctrl.ins && after) begin
         if (left_after) begin
            name_in = left_name;
            pri_in  = left_pri;
         end else begin
            name_in = new_name;
            pri_in  = new_pri;
         end
      end else if (ctrl.rem) begin
         name_in = right_name;
         pri_in  = right_pri;
      end
   end

   always_ff @(posedge clock) begin
      name_ff <= name_in;
      pri_ff  <= pri_in;
   end

   assign name = name_ff;
   assign pri  = pri_ff;

endmodule

### rtl/stable_priority_queue.sv
// Stable priority queue of process entries, built as a row of sorted cells.
// Request channel (req_valid/req_ready): req_operation selects insert or
// execute; an insert carries req_process_name and req_priority_req.
// Response channel (rsp_valid/rsp_ready): exactly one response per request
// with status, the served entry on a good execute, and the occupancy.
// Latency: the response is registered and appears the cycle after the
// request is taken. Throughput: one request per cycle unless rsp_ready
// stalls; every cell compares its priority with the incoming one in parallel
// and all shift at once, so the compare across the cell row sets the cycle time.
// Lower priority numbers leave first; equal ones leave in arrival order.
// Full queue: insert answers overflow, contents unchanged. Empty queue:
// execute answers underflow. Reset clears the count and the response valid
// flag only; cell contents and response data are dead until written.
// A stalled response (rsp_ready low) holds the output register; a new
// request is taken only when that register is empty or being drained.
module stable_priority_queue #(
   parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [spq_pkg::NAME_W-1:0]        req_process_name,
   input  logic [PRIORITY_BITS-1:0]          req_priority_req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [spq_pkg::NAME_W-1:0]        rsp_served_name,
   output logic [spq_pkg::SERVED_PRI_W-1:0]  rsp_served_priority,
   output logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import spq_pkg::*;

   `include "stable_priority_queue_assert.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Entry count; cell i holds a live entry when i < count.
   logic [CNT_W-1:0] count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [NAME_W-1:0]        served_name_ff, served_name_in;
   logic [SERVED_PRI_W-1:0]  served_pri_ff, served_pri_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;

   logic accept, full, empty;
   cell_ctrl_type ctrl;

   logic [CAPACITY-1:0] occupied;
   logic [CAPACITY-1:0] cell_after;
   logic [NAME_W-1:0]        cell_name [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_pri  [CAPACITY];

   logic [SERVED_PRI_W-1:0] front_pri;

   // Output register empties or drains this cycle -> room for a new request.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   assign ctrl.ins = accept && (req_operation == OP_INSERT) && !full;
   assign ctrl.rem = accept && (req_operation == OP_EXECUTE) && !empty;

   // Cell row: each cell sees its neighbors; ends are tied off.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     l_after;
      logic [NAME_W-1:0]        l_name, r_name;
      logic [PRIORITY_BITS-1:0] l_pri, r_pri;

      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign l_after = 1'b0;
         assign l_name  = '0;
         assign l_pri   = '0;
      end else begin : g_mid_l
         assign l_after = cell_after[i-1];
         assign l_name  = cell_name[i-1];
         assign l_pri   = cell_pri[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_name = '0;
         assign r_pri  = '0;
      end else begin : g_mid_r
         assign r_name = cell_name[i+1];
         assign r_pri  = cell_pri[i+1];
      end

      spq_cell #(
         .PRI_W (PRIORITY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied[i]),
         .new_name   (req_process_name),
         .new_pri    (req_priority_req),
         .left_after (l_after),
         .left_name  (l_name),
         .left_pri   (l_pri),
         .right_name (r_name),
         .right_pri  (r_pri),
         .after      (cell_after[i]),
         .name       (cell_name[i]),
         .pri        (cell_pri[i])
      );
   end

   // Fit the front priority and the count into the fixed response widths.
   if (PRIORITY_BITS >= SERVED_PRI_W) begin : g_pri_trunc
      assign front_pri = cell_pri[0][SERVED_PRI_W-1:0];
   end else begin : g_pri_ext
      assign front_pri = {{(SERVED_PRI_W - PRIORITY_BITS){1'b0}}, cell_pri[0]};
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   if (CNT_W >= OCC_W) begin : g_occ_trunc
      assign occ_in = count_in[OCC_W-1:0];
   end else begin : g_occ_ext
      assign occ_in = {{(OCC_W - CNT_W){1'b0}}, count_in};
   end

   always_comb begin
      status_in      = ST_OK;
      served_name_in = '0;
      served_pri_in  = '0;
      if (req_operation == OP_INSERT) begin
         if (full) begin
            status_in = ST_OVERFLOW;
         end
      end else begin
         if (empty) begin
            status_in = ST_UNDERFLOW;
         end else begin
            served_name_in = cell_name[0];
            served_pri_in  = front_pri;
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         served_name_ff <= served_name_in;
         served_pri_ff  <= served_pri_in;
         occ_ff         <= occ_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_served_name     = served_name_ff;
   assign rsp_served_priority = served_pri_ff;
   assign rsp_occupancy       = occ_ff;

   // Count stays within the cell row.
   `SPQ_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   // A taken insert grows the queue by exactly one.
   `SPQ_ASSERT_NEXT(a_ins_count, clock, reset, ctrl.ins, count_ff == $past(count_ff) + CNT_W'(1))
   // The two front entries stay in priority order.
   `SPQ_ASSERT_IMPL(a_front_sorted, clock, reset, count_ff >= CNT_W'(2), cell_pri[0] <= cell_pri[1])

endmodule

### tb/stable_priority_queue_test.sv
module stable_priority_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int PRI_W       = PRIORITY_BITS_DEF;
   localparam int DEPTH       = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 200000;   // hard stop, well above the slowest legal run
   localparam int HOLD_CYCLES = 80;       // long response back-pressure window

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [PRI_W-1:0]  pri;
   } proc_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [NAME_W-1:0]       name;
      logic [SERVED_PRI_W-1:0] pri;
      logic [OCC_W-1:0]        occ;
   } queue_result_type;

   // Mirror of the sorted queue plus the responses it still owes.
   class queue_scoreboard;
      proc_entry_type   held[$];
      queue_result_type owed[$];
      int fails, checked, inserts, executes, underflows, overflows, peak_occ;

      function void note_request(logic op, logic [NAME_W-1:0] name, logic [PRI_W-1:0] pri);
         queue_result_type r;
         proc_entry_type   e;
         int               pos;
         r = '0;
         if (op == OP_INSERT) begin
            inserts++;
            if (held.size() >= DEPTH) begin
               r.status = ST_OVERFLOW;
               overflows++;
            end else begin
               // stable: goes behind every entry with priority <= its own
               pos = 0;
               while (pos < held.size() && held[pos].pri <= pri)
                  pos++;
               e.name = name;
               e.pri  = pri;
               held.insert(pos, e);
            end
         end else begin
            executes++;
            if (held.size() == 0) begin
               r.status = ST_UNDERFLOW;
               underflows++;
            end else begin
               e      = held.pop_front();
               r.name = e.name;
               r.pri  = SERVED_PRI_W'(e.pri);
            end
         end
         r.occ = OCC_W'(held.size());
         if (held.size() > peak_occ)
            peak_occ = held.size();
         owed.push_back(r);
      endfunction

      function void flag(string field, longint unsigned want, longint unsigned got);
         $display("time %0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         fails++;
      endfunction

      function void check_response(queue_result_type got);
         queue_result_type want;
         if (owed.size() == 0) begin
            $display("time %0t: response with no request outstanding, actual %p", $time, got);
            fails++;
            return;
         end
         want = owed.pop_front();
         checked++;
         if (got.status !== want.status) flag("status", want.status, got.status);
         if (got.name !== want.name) flag("served_name", want.name, got.name);
         if (got.pri !== want.pri) flag("served_priority", want.pri, got.pri);
         if (got.occ !== want.occ) flag("occupancy", want.occ, got.occ);
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_operation = OP_INSERT;
   logic [NAME_W-1:0]       req_process_name = '0;
   logic [PRI_W-1:0]        req_priority_req = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [NAME_W-1:0]       rsp_served_name;
   logic [SERVED_PRI_W-1:0] rsp_served_priority;
   logic [OCC_W-1:0]        rsp_occupancy;

   queue_scoreboard sb = new();

   int send_idle_pct = 0;   // chance per cycle that the sender sits idle
   int rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
   int holds_ordered = 0;   // bumped by stimulus to ask for a long stall
   int cycle_count   = 0;

   stable_priority_queue dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_process_name   (req_process_name),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_served_name    (rsp_served_name),
      .rsp_served_priority(rsp_served_priority),
      .rsp_occupancy      (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed", cycle_count, sb.pending());
         $display("stable_priority_queue regression: fail");
         $finish;
      end
   end

   // Offer one request; valid stays up with a steady payload until it is taken.
   // Idle cycles are only inserted before raising valid, so valid is never
   // dropped and re-raised in the same step.
   task automatic send_request(logic op, logic [NAME_W-1:0] name, logic [PRI_W-1:0] pri);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_process_name <= name;
      req_priority_req <= pri;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(op, name, pri);
   endtask

   // Random request: insert_pct biases toward filling or draining; narrow
   // priorities make ties (and so the arrival-order rule) common.
   task automatic send_random(int insert_pct);
      logic [PRI_W-1:0] pri;
      case ($urandom_range(9))
         0, 1, 2, 3: pri = PRI_W'($urandom_range(3));
         4, 5:       pri = PRI_W'($urandom_range(15));
         6:          pri = $urandom_range(1) ? '1 : '0;
         default:    pri = PRI_W'($urandom);
      endcase
      send_request(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXECUTE,
                   NAME_W'($urandom), pri);
   endtask

   // Bursts of fill-heavy and drain-heavy traffic so the queue swings between
   // empty (underflow) and full (overflow) many times.
   task automatic random_phase(int count);
      int left, burst, bias;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(60, 10);
         case ($urandom_range(3))
            0:       bias = 10;
            1:       bias = 50;
            2:       bias = 65;
            default: bias = 92;
         endcase
         for (int i = 0; i < burst && left > 0; i++) begin
            send_random(bias);
            left--;
         end
      end
   endtask

   // Response side: random stalls, plus a long hold when stimulus asks for one.
   initial begin
      int holds_served;
      int hold_left;
      queue_result_type got;
      holds_served = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            got.status = rsp_status;
            got.name   = rsp_served_name;
            got.pri    = rsp_served_priority;
            got.occ    = rsp_occupancy;
            sb.check_response(got);
         end
         if (holds_served != holds_ordered) begin
            holds_served = holds_ordered;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow on empty, field extremes, ties kept in arrival
      // order, drain back to empty.
      send_request(OP_EXECUTE, '1, '1);
      send_request(OP_INSERT, '1, '1);
      send_request(OP_INSERT, '0, '0);
      send_request(OP_INSERT, 24'h414243, 8'd7);
      send_request(OP_INSERT, 24'h444546, 8'd7);
      send_request(OP_INSERT, 24'h474849, 8'd7);
      send_request(OP_INSERT, 24'h5a5a5a, '1);
      send_request(OP_INSERT, 24'h555555, 8'h80);
      send_request(OP_INSERT, 24'haaaaaa, 8'h01);
      repeat (9) send_request(OP_EXECUTE, 24'h123456, 8'h55);

      // Fill to capacity, then hit overflow.
      for (int i = 0; i < DEPTH + 1; i++)
         send_request(OP_INSERT, NAME_W'($urandom), PRI_W'($urandom_range(3)));

      // Long response stall while requests keep coming: output register fills,
      // request side must back off.
      holds_ordered <= holds_ordered + 1;
      for (int i = 0; i < 40; i++)
         send_random(30);

      // Phase 1: no idling on either side.
      random_phase(250);

      // Phase 2: sender mostly idle.
      send_idle_pct = 68;
      rsp_stall_pct = 0;
      random_phase(250);

      // Phase 3: receiver mostly stalling.
      send_idle_pct = 0;
      rsp_stall_pct = 68;
      random_phase(250);

      // Phase 4: light idling on both sides.
      send_idle_pct = 12;
      rsp_stall_pct = 12;
      random_phase(330);

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d inserts (%0d overflowed) and %0d executes (%0d underflowed)",
               sb.inserts, sb.overflows, sb.executes, sb.underflows);
      $display("%0d responses checked, peak occupancy %0d, %0d errors",
               sb.checked, sb.peak_occ, sb.fails);
      if (sb.fails == 0)
         $display("stable_priority_queue regression: pass");
      else
         $display("stable_priority_queue regression: fail");
      $finish;
   end

endmodule
